>>> hdl/pwrd_pkg.sv
// Package for the pulse width remote decoder: codes, constants and command shaping.
`timescale 1ns / 1ps
package pwrd_pkg;

	localparam int unsigned WidthW = 16;
	localparam int unsigned LimitW = 10;
	localparam int unsigned ScaleW = 8;
	localparam int unsigned CalibW = 3;
	localparam int unsigned CmdW   = 9;

	localparam logic [WidthW-1:0] RecalTop   = 16'd12000;
	localparam logic [WidthW-1:0] AutoOnTop  = 16'd15000;
	localparam logic [WidthW-1:0] AutoOffTop = 16'd18000;
	localparam logic [WidthW-1:0] XLearnTop  = 16'd4000;
	localparam logic [WidthW-1:0] YLearnTop  = 16'd7000;

	localparam logic [WidthW-1:0] MinPulseRst  = 16'd2000;
	localparam logic [WidthW-1:0] XBandTopRst  = 16'd4400;
	localparam logic [WidthW-1:0] YBandTopRst  = 16'd7000;
	localparam logic [LimitW-1:0] RejectRst    = 10'd230;
	localparam logic [LimitW-1:0] SnapRst      = 10'd190;
	localparam logic [ScaleW-1:0] FullScaleRst = 8'd200;
	localparam logic [ScaleW-1:0] DeadBandRst  = 8'd15;
	localparam logic [CalibW-1:0] CalibRst     = 3'd3;

	localparam logic signed [16:0] HeldMax = 17'sd255;
	localparam logic signed [16:0] HeldMin = -17'sd255;

	typedef enum logic [2:0] {
		CLS_IGNORED  = 3'd0,
		CLS_X        = 3'd1,
		CLS_Y        = 3'd2,
		CLS_RECAL    = 3'd3,
		CLS_AUTO_ON  = 3'd4,
		CLS_AUTO_OFF = 3'd5,
		CLS_BEYOND   = 3'd6
	} pulse_class_t;

	typedef enum logic [2:0] {
		REG_MIN_PULSE    = 3'd0,
		REG_X_BAND_TOP   = 3'd1,
		REG_Y_BAND_TOP   = 3'd2,
		REG_REJECT_LIMIT = 3'd3,
		REG_SNAP_LIMIT   = 3'd4,
		REG_FULL_SCALE   = 3'd5,
		REG_DEAD_BAND    = 3'd6,
		REG_CALIB_PULSES = 3'd7
	} reg_index_t;

	// width minus centre, shaped by reject / snap / dead band, clamped to +/-255
	function automatic logic signed [CmdW-1:0] shape_cmd(
		input logic [WidthW-1:0] width,
		input logic [WidthW-1:0] centre,
		input logic [LimitW-1:0] reject_lim,
		input logic [LimitW-1:0] snap_lim,
		input logic [ScaleW-1:0] full_sc,
		input logic [ScaleW-1:0] dead_bd
	);
		logic signed [16:0] offset;
		logic [16:0]        mag;
		logic signed [16:0] cmd;
		offset = $signed({1'b0, width}) - $signed({1'b0, centre});
		mag    = offset[16] ? 17'(-offset) : 17'(offset);
		if (mag >= {7'd0, reject_lim}) begin
			cmd = '0;
		end else if (mag >= {7'd0, snap_lim}) begin
			cmd = offset[16] ? -$signed({9'd0, full_sc}) : $signed({9'd0, full_sc});
		end else if (mag <= {9'd0, dead_bd}) begin
			cmd = '0;
		end else begin
			cmd = offset;
		end
		if (cmd > HeldMax) begin
			cmd = HeldMax;
		end
		if (cmd < HeldMin) begin
			cmd = HeldMin;
		end
		return cmd[CmdW-1:0];
	endfunction

endpackage

>>> hdl/pulse_width_remote_decoder_unit.sv
// Top level of the pulse width remote decoder.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / pulse_width) carries one measured
//   pulse width per transaction. Output channel (out_valid / out_stall) gives
//   one result per input transaction: the held x and y commands, the mode
//   flag and the class of that pulse.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   eight tuning registers; cfg_ready is always high. Write only while idle.
// Timing:
//   A pulse is captured in the input register, decoded by one level of
//   compare/subtract logic and lands in the result register once that
//   register is free. One pulse per cycle is sustained while out_stall is
//   low; the decoder state feeds back within that single stage.
// Reset:
//   arst_n clears both stages, loads the default tuning values, zeroes the
//   centres and held commands, sets auto mode and a calibration count of 3.
// Stall:
//   While out_stall holds a result, the input register keeps its pulse and
//   in_stall rises once that register is full; no state moves meanwhile.
module pulse_width_remote_decoder_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pwrd_pkg::WidthW-1:0]           pulse_width,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pwrd_pkg::CmdW-1:0]      x_command,
	output logic signed [pwrd_pkg::CmdW-1:0]      y_command,
	output logic                                  auto_enabled,
	output logic [2:0]                            pulse_class,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [2:0]                            cfg_index,
	input  logic [pwrd_pkg::WidthW-1:0]           cfg_data
);
	import pwrd_pkg::*;

	// tuning registers
	logic [WidthW-1:0] min_pulse_q, x_band_top_q, y_band_top_q;
	logic [LimitW-1:0] reject_limit_q, snap_limit_q;
	logic [ScaleW-1:0] full_scale_q, dead_band_q;
	logic [CalibW-1:0] calib_pulses_q;

	// decoder state; held commands and mode double as the result payload
	logic [WidthW-1:0]      x_centre_q, y_centre_q;
	logic [CalibW-1:0]      calib_rem_q;
	logic signed [CmdW-1:0] x_held_q, y_held_q;
	logic                   auto_q;
	pulse_class_t           class_q;
	logic                   out_valid_q;

	// input stage
	logic              valid_s1;
	logic [WidthW-1:0] width_s1;

	logic out_free, advance;

	// next-state values of the decode
	pulse_class_t           cls;
	logic signed [CmdW-1:0] x_nxt, y_nxt;
	logic                   auto_nxt;
	logic [CalibW-1:0]      rem_band, rem_nxt;
	logic [WidthW-1:0]      xc_nxt, yc_nxt;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	assign out_valid    = out_valid_q;
	assign x_command    = x_held_q;
	assign y_command    = y_held_q;
	assign auto_enabled = auto_q;
	assign pulse_class  = class_q;

	// band sort and command shaping
	always_comb begin
		cls      = CLS_IGNORED;
		x_nxt    = x_held_q;
		y_nxt    = y_held_q;
		auto_nxt = auto_q;
		rem_band = calib_rem_q;
		rem_nxt  = calib_rem_q;
		xc_nxt   = x_centre_q;
		yc_nxt   = y_centre_q;
		if (width_s1 > min_pulse_q) begin
			if (width_s1 <= x_band_top_q) begin
				cls   = CLS_X;
				x_nxt = shape_cmd(width_s1, x_centre_q, reject_limit_q, snap_limit_q,
					full_scale_q, dead_band_q);
			end else if (width_s1 <= y_band_top_q) begin
				cls   = CLS_Y;
				y_nxt = shape_cmd(width_s1, y_centre_q, reject_limit_q, snap_limit_q,
					full_scale_q, dead_band_q);
			end else if (width_s1 <= RecalTop) begin
				cls      = CLS_RECAL;
				rem_band = calib_pulses_q;
			end else if (width_s1 <= AutoOnTop) begin
				cls      = CLS_AUTO_ON;
				auto_nxt = 1'b1;
			end else if (width_s1 <= AutoOffTop) begin
				cls      = CLS_AUTO_OFF;
				auto_nxt = 1'b0;
			end else begin
				cls = CLS_BEYOND;
			end
			// centre learning, counted after the band action
			rem_nxt = rem_band;
			if (rem_band != '0) begin
				rem_nxt = rem_band - CalibW'(1);
				if (width_s1 <= XLearnTop) begin
					xc_nxt = width_s1;
				end else if (width_s1 <= YLearnTop) begin
					yc_nxt = width_s1;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			width_s1 <= pulse_width;
		end
	end

	// result register and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			class_q     <= CLS_IGNORED;
			x_held_q    <= '0;
			y_held_q    <= '0;
			auto_q      <= 1'b1;
			calib_rem_q <= CalibRst;
			x_centre_q  <= '0;
			y_centre_q  <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				class_q     <= cls;
				x_held_q    <= x_nxt;
				y_held_q    <= y_nxt;
				auto_q      <= auto_nxt;
				calib_rem_q <= rem_nxt;
				x_centre_q  <= xc_nxt;
				y_centre_q  <= yc_nxt;
			end
		end
	end

	// tuning register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q    <= MinPulseRst;
			x_band_top_q   <= XBandTopRst;
			y_band_top_q   <= YBandTopRst;
			reject_limit_q <= RejectRst;
			snap_limit_q   <= SnapRst;
			full_scale_q   <= FullScaleRst;
			dead_band_q    <= DeadBandRst;
			calib_pulses_q <= CalibRst;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_MIN_PULSE:    min_pulse_q    <= cfg_data;
				REG_X_BAND_TOP:   x_band_top_q   <= cfg_data;
				REG_Y_BAND_TOP:   y_band_top_q   <= cfg_data;
				REG_REJECT_LIMIT: reject_limit_q <= cfg_data[LimitW-1:0];
				REG_SNAP_LIMIT:   snap_limit_q   <= cfg_data[LimitW-1:0];
				REG_FULL_SCALE:   full_scale_q   <= cfg_data[ScaleW-1:0];
				REG_DEAD_BAND:    dead_band_q    <= cfg_data[ScaleW-1:0];
				REG_CALIB_PULSES: calib_pulses_q <= cfg_data[CalibW-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> bench/tb_pulse_width_remote_decoder_unit.sv
// Self-checking testbench for the pulse width remote decoder: predictor, driver, monitor.
`timescale 1ns / 1ps
module tb_pulse_width_remote_decoder_unit;
	import pwrd_pkg::*;

	// generous bound on the whole run, in clock cycles
	localparam int RunLimit = 400000;
	// receiver hold-off used to back the pipe up into the input side
	localparam int LongHoldCycles = 120;

	// one decoded result as the block should present it
	typedef struct {
		logic signed [CmdW-1:0] x_cmd;
		logic signed [CmdW-1:0] y_cmd;
		logic                   auto_on;
		pulse_class_t           cls;
	} decode_result_t;

	// ------------------------------------------------------------------
	// DUT signals, all inputs known from time zero
	// ------------------------------------------------------------------
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [WidthW-1:0]      pulse_width = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic signed [CmdW-1:0] x_command;
	logic signed [CmdW-1:0] y_command;
	logic                   auto_enabled;
	logic [2:0]             pulse_class;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [2:0]             cfg_index = '0;
	logic [WidthW-1:0]      cfg_data = '0;

	pulse_width_remote_decoder_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pulse_width  (pulse_width),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.x_command    (x_command),
		.y_command    (y_command),
		.auto_enabled (auto_enabled),
		.pulse_class  (pulse_class),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------
	// Tuning registers as the testbench last wrote them (reset values first).
	// Only the stimulus process writes these, and only while the block is idle.
	// ------------------------------------------------------------------
	logic [WidthW-1:0] min_pulse_cfg  = MinPulseRst;
	logic [WidthW-1:0] x_top_cfg      = XBandTopRst;
	logic [WidthW-1:0] y_top_cfg      = YBandTopRst;
	logic [LimitW-1:0] reject_cfg     = RejectRst;
	logic [LimitW-1:0] snap_cfg       = SnapRst;
	logic [ScaleW-1:0] full_scale_cfg = FullScaleRst;
	logic [ScaleW-1:0] dead_band_cfg  = DeadBandRst;
	logic [CalibW-1:0] calib_cfg      = CalibRst;

	// Decoder state mirror, owned by the driver process
	logic [WidthW-1:0]      x_centre   = '0;
	logic [WidthW-1:0]      y_centre   = '0;
	logic [CalibW-1:0]      calib_left = CalibRst;
	logic signed [CmdW-1:0] x_hold     = '0;
	logic signed [CmdW-1:0] y_hold     = '0;
	logic                   auto_sel   = 1'b1;

	// pulses waiting to be offered, and decoded results still owed by the block
	logic [WidthW-1:0] pulse_queue [$];
	decode_result_t    decode_expect [$];

	// idle rates in percent, changed by the stimulus process at falling edges
	int snd_idle_pct = 19;
	int rcv_idle_pct = 59;

	// long receiver hold-off: request count from stimulus, ack and countdown here
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	int fail_count = 0;
	int results_seen = 0;
	int cycle_count = 0;

	// stimulus shaping: centres the generator believes it taught last
	int gen_x_centre = 3000;
	int gen_y_centre = 5500;

	// Directed opening. With the reset tuning: one ignored pulse at the
	// threshold, two learning pulses, a recalibrate, two more learning pulses
	// (centres 3500 / 6000), then commands in the dead band, just outside it,
	// plain offsets, snap edges on both axes, reject edges on x, the mode
	// bands at their edges, beyond bands, both field extremes, band tops and a
	// recalibrate that restarts learning.
	int directed_widths [25] = '{
		2000, 3000, 5500, 12000, 3500, 6000,
		3510, 3516, 3400, 3690, 3271, 3730, 6050, 5809,
		15000, 15001, 18000, 18001, 65535, 0,
		4400, 4401, 7000, 7001, 2001
	};

	// ------------------------------------------------------------------
	// Clock and the single reset
	// ------------------------------------------------------------------
	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// offset shaping: reject beats snap beats dead band; clamp to +/-255 (9-bit command)
	function automatic logic signed [CmdW-1:0] shaped_command(input int offset);
		int mag;
		int cmd;
		mag = (offset < 0) ? -offset : offset;
		if (mag >= int'(reject_cfg)) begin
			cmd = 0;
		end else if (mag >= int'(snap_cfg)) begin
			cmd = (offset < 0) ? -int'(full_scale_cfg) : int'(full_scale_cfg);
		end else if (mag <= int'(dead_band_cfg)) begin
			cmd = 0;
		end else begin
			cmd = offset;
		end
		if (cmd > 255) begin
			cmd = 255;
		end
		if (cmd < -255) begin
			cmd = -255;
		end
		return cmd[CmdW-1:0];
	endfunction

	// advance the mirror by one accepted pulse and queue the result it owes
	task automatic decode_pulse(input logic [WidthW-1:0] w);
		decode_result_t res;
		pulse_class_t   cls;
		if (w <= min_pulse_cfg) begin
			cls = CLS_IGNORED;
		end else begin
			// first matching band wins, so overlapping settings resolve here
			if (w <= x_top_cfg) begin
				cls = CLS_X;
				x_hold = shaped_command(int'(w) - int'(x_centre));
			end else if (w <= y_top_cfg) begin
				cls = CLS_Y;
				y_hold = shaped_command(int'(w) - int'(y_centre));
			end else if (w <= RecalTop) begin
				cls = CLS_RECAL;
				calib_left = calib_cfg;
			end else if (w <= AutoOnTop) begin
				cls = CLS_AUTO_ON;
				auto_sel = 1'b1;
			end else if (w <= AutoOffTop) begin
				cls = CLS_AUTO_OFF;
				auto_sel = 1'b0;
			end else begin
				cls = CLS_BEYOND;
			end
			// learning runs after the band action, so a command uses the old centre
			if (calib_left != 0) begin
				calib_left = calib_left - CalibW'(1);
				if (w <= XLearnTop) begin
					x_centre = w;
				end else if (w <= YLearnTop) begin
					y_centre = w;
				end
			end
		end
		res.x_cmd   = x_hold;
		res.y_cmd   = y_hold;
		res.auto_on = auto_sel;
		res.cls     = cls;
		decode_expect.push_back(res);
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] result %0d: %s got %0d, expected %0d",
			$time, results_seen, what, got, want);
		fail_count++;
	endtask

	task automatic check_result();
		decode_result_t want;
		if (decode_expect.size() == 0) begin
			report_mismatch("unexpected result, pulse_class", int'(pulse_class), -1);
		end else begin
			want = decode_expect.pop_front();
			if (x_command !== want.x_cmd) begin
				report_mismatch("x_command", int'(x_command), int'(want.x_cmd));
			end
			if (y_command !== want.y_cmd) begin
				report_mismatch("y_command", int'(y_command), int'(want.y_cmd));
			end
			if (auto_enabled !== want.auto_on) begin
				report_mismatch("auto_enabled", int'(auto_enabled), int'(want.auto_on));
			end
			if (pulse_class !== want.cls) begin
				report_mismatch("pulse_class", int'(pulse_class), int'(want.cls));
			end
		end
		results_seen++;
	endtask

	// ------------------------------------------------------------------
	// Driver: predicts on each accepted transaction, then offers the next
	// pulse from the queue unless it decides to idle. A pending pulse is
	// held steady while stalled.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_pulse(pulse_width);
			end
			if (!in_valid || !in_stall) begin
				if (pulse_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
					in_valid    <= 1'b1;
					pulse_width <= pulse_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long hold-off counter, kept in its own process
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_ack != hold_req) begin
			hold_ack  <= hold_req;
			hold_left <= LongHoldCycles;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each accepted result, then picks the next stall value
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_result();
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RunLimit) begin
			$display("pulse_width_remote_decoder_unit regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// returns 1 when the pulse should do something under the current tuning
	function automatic int queue_pulse(input int w);
		logic [WidthW-1:0] width;
		if (w < 0) begin
			w = 0;
		end
		if (w > 65535) begin
			w = 65535;
		end
		width = w[WidthW-1:0];
		pulse_queue.push_back(width);
		return (width > min_pulse_cfg) ? 1 : 0;
	endfunction

	// random traffic biased toward well-formed use: recalibrate + learning
	// sequences, then commands around the taught centres; the rest is mode
	// pulses, out of band pulses, sub-threshold noise and raw 16-bit values
	task automatic queue_random_pulses(input int count);
		int made;
		int pick;
		int span;
		int base;
		int k;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				made += queue_pulse($urandom_range(7001, 12000));
				for (k = 0; k < int'(calib_cfg); k++) begin
					if (k % 2 == 0) begin
						gen_x_centre = $urandom_range(2001, 4000);
						made += queue_pulse(gen_x_centre);
					end else begin
						gen_y_centre = $urandom_range(4001, 7000);
						made += queue_pulse(gen_y_centre);
					end
				end
			end else if (pick < 62) begin
				span = int'(reject_cfg) + 24;
				base = ($urandom_range(1) != 0) ? gen_x_centre : gen_y_centre;
				made += queue_pulse(base + int'($urandom_range(2 * span)) - span);
			end else if (pick < 74) begin
				made += queue_pulse($urandom_range(12001, 18000));
			end else if (pick < 80) begin
				made += queue_pulse($urandom_range(18001, 65535));
			end else if (pick < 88) begin
				made += queue_pulse($urandom_range(int'(min_pulse_cfg)));
			end else begin
				made += queue_pulse($urandom_range(65535));
			end
		end
	endtask

	// everything offered, accepted and answered
	task automatic wait_drained();
		@(negedge clk);
		while (pulse_queue.size() != 0 || in_valid || decode_expect.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic write_register(input reg_index_t idx, input logic [WidthW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		// ready seen at the falling edge is what the next rising edge uses
		@(negedge clk);
		while (!cfg_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MIN_PULSE:    min_pulse_cfg  = value;
			REG_X_BAND_TOP:   x_top_cfg      = value;
			REG_Y_BAND_TOP:   y_top_cfg      = value;
			REG_REJECT_LIMIT: reject_cfg     = value[LimitW-1:0];
			REG_SNAP_LIMIT:   snap_cfg       = value[LimitW-1:0];
			REG_FULL_SCALE:   full_scale_cfg = value[ScaleW-1:0];
			REG_DEAD_BAND:    dead_band_cfg  = value[ScaleW-1:0];
			REG_CALIB_PULSES: calib_cfg      = value[CalibW-1:0];
			default: ;
		endcase
	endtask

	// new tuning, written only once the pipe is empty and settled
	task automatic apply_settings(input int min_p, input int x_top, input int y_top,
			input int reject, input int snap, input int full, input int dead,
			input int calib);
		wait_drained();
		repeat (3) @(posedge clk);
		write_register(REG_MIN_PULSE, min_p[WidthW-1:0]);
		write_register(REG_X_BAND_TOP, x_top[WidthW-1:0]);
		write_register(REG_Y_BAND_TOP, y_top[WidthW-1:0]);
		write_register(REG_REJECT_LIMIT, reject[WidthW-1:0]);
		write_register(REG_SNAP_LIMIT, snap[WidthW-1:0]);
		write_register(REG_FULL_SCALE, full[WidthW-1:0]);
		write_register(REG_DEAD_BAND, dead[WidthW-1:0]);
		write_register(REG_CALIB_PULSES, calib[WidthW-1:0]);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence. Queue pushes and knob changes happen at falling edges,
	// away from the rising edge where the driver and monitor run.
	// ------------------------------------------------------------------
	initial begin
		int i;
		@(posedge arst_n);
		@(negedge clk);

		// sender idles now and then, receiver stalls often
		snd_idle_pct = 19;
		rcv_idle_pct = 59;

		// reset tuning: directed opening, then random traffic
		for (i = 0; i < 25; i++) begin
			void'(queue_pulse(directed_widths[i]));
		end
		queue_random_pulses(300);

		// no threshold, wide limits: unsnapped offsets beyond 255 clamp;
		// y band swallows part of the recalibrate band; longest learning run
		apply_settings(0, 3000, 9000, 1023, 1023, 255, 0, 7);
		queue_random_pulses(300);

		// roles swap: sender idles often, receiver stalls now and then
		snd_idle_pct = 59;
		rcv_idle_pct = 19;

		// threshold at the top: every pulse is ignored
		apply_settings(65535, 65535, 65535, 0, 0, 0, 0, 0);
		for (i = 0; i < 30; i++) begin
			void'(queue_pulse($urandom_range(65535)));
		end

		// y band empty behind x, everything rejected, learning off
		apply_settings(1000, 8000, 5000, 0, 0, 0, 255, 0);
		queue_random_pulses(250);

		// moderate limits with full scale at the 8-bit top
		apply_settings(1500, 4400, 7000, 600, 300, 255, 40, 5);
		queue_random_pulses(400);

		// no idling from here on
		snd_idle_pct = 0;
		rcv_idle_pct = 0;

		// x band empty, y covers the rest; zero snap limit so everything
		// short of reject snaps. Receiver holds off for a long stretch while
		// the sender keeps offering, so the input side has to stall.
		apply_settings(2000, 0, 65535, 300, 0, 128, 255, 1);
		hold_req = hold_req + 1;
		queue_random_pulses(250);

		// back to the reset tuning, written explicitly
		apply_settings(int'(MinPulseRst), int'(XBandTopRst), int'(YBandTopRst),
			int'(RejectRst), int'(SnapRst), int'(FullScaleRst), int'(DeadBandRst),
			int'(CalibRst));
		queue_random_pulses(400);

		wait_drained();
		repeat (4) @(posedge clk);
		if (decode_expect.size() != 0) begin
			report_mismatch("results never delivered", decode_expect.size(), 0);
		end
		if (fail_count == 0) begin
			$display("pulse_width_remote_decoder_unit regression: pass");
		end else begin
			$display("pulse_width_remote_decoder_unit regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/pwrd_pkg.sv
hdl/pulse_width_remote_decoder_unit.sv
bench/tb_pulse_width_remote_decoder_unit.sv
